@@ hw/rtl/deq_pkg.sv @@
// Shared types, codes and sizes for the double-ended queue.
`timescale 1ns / 1ps
package deq_pkg;

  // Payload widths
  localparam int VALUE_W    = 32;
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Default ring depth
  localparam int DEPTH_DEF = 32;

  // Command queue between front and back
  localparam int CMDQ_AW    = 2;
  localparam int CMDQ_DEPTH = 1 << CMDQ_AW;

  // Operation codes on the input channel
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Classified command kinds
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_DUMP = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic                      at_front;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

@@ hw/rtl/deq_front.sv @@
// Front end: accepts requests, decodes the op and stages a command.
`timescale 1ns / 1ps
module deq_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [deq_pkg::OP_W-1:0]       in_op,
  input  logic signed [deq_pkg::VALUE_W-1:0] in_value,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output deq_pkg::cmd_t                  cmd
);
  import deq_pkg::*;

  logic fvalid;
  cmd_t fcmd;
  cmd_t dec_cmd;
  logic dec_ok;

  // Decode op into a command kind; unused codes are dropped here
  always_comb begin
    dec_cmd.value    = in_value;
    dec_cmd.at_front = 1'b0;
    dec_cmd.kind     = CMD_PUSH;
    dec_ok           = 1'b1;
    case (in_op)
      OP_PUSH_FRONT: begin
        dec_cmd.kind     = CMD_PUSH;
        dec_cmd.at_front = 1'b1;
      end
      OP_PUSH_BACK: dec_cmd.kind = CMD_PUSH;
      OP_POP_FRONT: begin
        dec_cmd.kind     = CMD_POP;
        dec_cmd.at_front = 1'b1;
      end
      OP_POP_BACK: dec_cmd.kind = CMD_POP;
      OP_DUMP:     dec_cmd.kind = CMD_DUMP;
      default:     dec_ok = 1'b0;
    endcase
  end

  assign in_ready  = !fvalid || cmd_ready;
  assign cmd_valid = fvalid;
  assign cmd       = fcmd;

  // Staging register
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (in_valid && in_ready) begin
      fvalid <= dec_ok;
    end else if (cmd_ready) begin
      fvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fcmd <= dec_cmd;
    end
  end

endmodule

@@ hw/rtl/deq_cmdq.sv @@
// Small command FIFO that decouples the front end from the executor.
`timescale 1ns / 1ps
module deq_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  deq_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output deq_pkg::cmd_t rd_cmd
);
  import deq_pkg::*;

  cmd_t               entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr;
  logic [CMDQ_AW-1:0] rptr;
  logic [CMDQ_AW:0]   fill;
  logic               do_wr;
  logic               do_rd;

  assign wr_ready = fill != (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_cmd   = entries[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wptr] <= wr_cmd;
  end

endmodule

@@ hw/rtl/deq_back.sv @@
// Executor: ring storage, head/count bookkeeping and the result register.
`timescale 1ns / 1ps
module deq_back #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  deq_pkg::cmd_t                     cmd,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic signed [deq_pkg::VALUE_W-1:0] res_value,
  output logic [deq_pkg::STATUS_W-1:0]      res_status,
  output logic                              res_last
);
  import deq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state;
  logic [PTR_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   dump_idx;
  logic               dumping;

  logic signed [VALUE_W-1:0] ring [DEPTH];
  logic signed [VALUE_W-1:0] rd_data;

  // Pending result, moved to the output register when it is free
  logic signed [VALUE_W-1:0] pend_value;
  logic [STATUS_W-1:0]       pend_status;
  logic                      pend_last;

  logic               out_free;
  logic               is_full;
  logic               is_empty;
  logic [PTR_W-1:0]   head_dec;
  logic [PTR_W-1:0]   head_inc;
  logic [CNT_W-1:0]   off;
  logic [CNT_W:0]     pos_sum;
  logic [PTR_W-1:0]   ring_addr;
  logic               mem_we;
  logic               mem_re;
  logic [PTR_W-1:0]   mem_waddr;
  logic [PTR_W-1:0]   mem_raddr;
  logic               take;
  logic               dump_more;

  assign out_free  = !res_valid || res_ready;
  assign is_full   = count == CNT_W'(DEPTH);
  assign is_empty  = count == '0;
  assign cmd_ready = state == S_IDLE;
  assign take      = cmd_valid && cmd_ready;
  assign dump_more = dumping && !pend_last;

  // Head neighbors with wrap at DEPTH
  assign head_dec = (head == '0) ? PTR_W'(DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;

  // Ring position head + offset, one conditional subtract
  always_comb begin
    if (state == S_EMIT) begin
      off = dump_idx + 1'b1;
    end else if (cmd.kind == CMD_PUSH) begin
      off = count;
    end else begin
      off = count - 1'b1;
    end
    pos_sum = (CNT_W+1)'(head) + {1'b0, off};
    if (pos_sum >= (CNT_W+1)'(DEPTH)) begin
      pos_sum = pos_sum - (CNT_W+1)'(DEPTH);
    end
    ring_addr = pos_sum[PTR_W-1:0];
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cmd.at_front ? head_dec : ring_addr;
    mem_raddr = ring_addr;
    if (take) begin
      case (cmd.kind)
        CMD_PUSH: mem_we = !is_full;
        CMD_POP: begin
          mem_re    = !is_empty;
          mem_raddr = cmd.at_front ? head : ring_addr;
        end
        CMD_DUMP: begin
          mem_re    = !is_empty;
          mem_raddr = head;
        end
        default: ;
      endcase
    end else if (state == S_EMIT && out_free && dump_more) begin
      mem_re = 1'b1;
    end
  end

  // Ring storage
  always_ff @(posedge clk) begin
    if (mem_we) ring[mem_waddr] <= cmd.value;
    if (mem_re) rd_data <= ring[mem_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      dumping   <= 1'b0;
      dump_idx  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_ready && !(state == S_EMIT && out_free)) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            pend_value <= '0;
            // Only a dump of two or more values leaves last low at first
            pend_last  <= (cmd.kind != CMD_DUMP) || is_empty || count == CNT_W'(1);
            case (cmd.kind)
              CMD_PUSH: begin
                state <= S_EMIT;
                if (is_full) begin
                  pend_status <= ST_FULL;
                end else begin
                  pend_status <= ST_OK;
                  count       <= count + 1'b1;
                  if (cmd.at_front) head <= head_dec;
                end
              end
              CMD_POP: begin
                if (is_empty) begin
                  pend_status <= ST_EMPTY;
                  state       <= S_EMIT;
                end else begin
                  pend_status <= ST_OK;
                  count       <= count - 1'b1;
                  if (cmd.at_front) head <= head_inc;
                  state <= S_READ;
                end
              end
              CMD_DUMP: begin
                if (is_empty) begin
                  pend_status <= ST_EMPTY;
                  state       <= S_EMIT;
                end else begin
                  pend_status <= ST_OK;
                  dumping     <= 1'b1;
                  dump_idx    <= '0;
                  state       <= S_READ;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          pend_value <= rd_data;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            res_value  <= pend_value;
            res_status <= pend_status;
            res_last   <= pend_last;
            if (dump_more) begin
              dump_idx  <= dump_idx + 1'b1;
              pend_last <= ({1'b0, dump_idx} + (CNT_W+1)'(2)) == {1'b0, count};
              state     <= S_READ;
            end else begin
              dumping <= 1'b0;
              state   <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/double_ended_queue.sv @@
// Top level of the double-ended queue: front end, command FIFO, executor.
//
// Usage:
//   Requests enter on s_axis: tuser carries the op (push front, push back,
//   pop front, pop back, dump), tdata the signed 32-bit value to push.
//   Unused op codes are consumed and produce no result.
//   Results leave on m_axis: tdata holds the value (popped or dumped, else
//   zero) and the status (ok, empty, full); tlast marks the final result of
//   a request. A dump gives one result per held value, front to back.
// Sequencing:
//   A request passes the front staging register and the command FIFO
//   before it reaches the executor. The executor steps from idle to emit
//   for a push or an empty answer and through read and emit for a pop; a
//   dump passes read and emit once per held value. The four-entry command
//   FIFO lets new requests be accepted while the executor is busy.
// Reset: rst (synchronous, active high) empties the queue and all buffers.
// Stall: when m_axis_tready is low the result register holds, the
//   executor waits, and s_axis_tready drops once the command FIFO and the
//   front stage are both full.
`timescale 1ns / 1ps
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [deq_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [31:0] value
  input  logic [deq_pkg::OP_W-1:0]          s_axis_tuser,  // [2:0] op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [deq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [31:0] value_res, [33:32] status
  output logic                              m_axis_tlast   // last
);
  import deq_pkg::*;

  logic                      fq_valid;
  logic                      fq_ready;
  cmd_t                      fq_cmd;
  logic                      qb_valid;
  logic                      qb_ready;
  cmd_t                      qb_cmd;
  logic signed [VALUE_W-1:0] res_value;
  logic [STATUS_W-1:0]       res_status;

  deq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_value  (s_axis_tdata[VALUE_W-1:0]),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  deq_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_cmd   (qb_cmd)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (qb_valid),
    .cmd_ready  (qb_ready),
    .cmd        (qb_cmd),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_value  (res_value),
    .res_status (res_status),
    .res_last   (m_axis_tlast)
  );

  // Pack result fields, zero fill to whole bytes
  assign m_axis_tdata = {{(OUT_DATA_W - VALUE_W - STATUS_W){1'b0}}, res_status, res_value};

endmodule

@@ sim/double_ended_queue_test.sv @@
// Self-checking testbench for the double-ended queue stream block.
`timescale 1ns / 1ps
module double_ended_queue_test;
  import deq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int NUM_ITEMS  = 430;
  localparam int IDLE_PCT   = 31;
  localparam int DRAIN_WAIT = 60;
  localparam int CYCLE_CAP  = 400000;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
  } deq_request_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic                      last;
  } deq_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // Stimulus still to send and results still owed by the block
  deq_request_t requests_todo[$];
  deq_result_t  results_due[$];

  // Shadow deque used for prediction
  logic signed [VALUE_W-1:0] shadow_ring[DEPTH];
  int shadow_head  = 0;
  int shadow_count = 0;

  int fail_cnt  = 0;
  int sent_cnt  = 0;
  int cycle_cnt = 0;
  logic steady;

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Neither side idles over a stretch of the run
  assign steady = (sent_cnt >= 180) && (sent_cnt < 260);

  function automatic deq_result_t make_result(logic signed [VALUE_W-1:0] v,
                                              logic [STATUS_W-1:0] st, logic lst);
    deq_result_t r;
    r.value  = v;
    r.status = st;
    r.last   = lst;
    return r;
  endfunction

  // Apply one request to the shadow deque and queue what it should return
  task automatic apply_deque_op(input logic [OP_W-1:0] op,
                                input logic signed [VALUE_W-1:0] v);
    logic signed [VALUE_W-1:0] got;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          results_due.push_back(make_result('0, ST_FULL, 1'b1));
        end else begin
          if (op == OP_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_ring[shadow_head] = v;
          end else begin
            shadow_ring[(shadow_head + shadow_count) % DEPTH] = v;
          end
          shadow_count++;
          results_due.push_back(make_result('0, ST_OK, 1'b1));
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_count == 0) begin
          results_due.push_back(make_result('0, ST_EMPTY, 1'b1));
        end else begin
          if (op == OP_POP_FRONT) begin
            got = shadow_ring[shadow_head];
            shadow_head = (shadow_head + 1) % DEPTH;
          end else begin
            got = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
          end
          shadow_count--;
          results_due.push_back(make_result(got, ST_OK, 1'b1));
        end
      end
      OP_DUMP: begin
        if (shadow_count == 0) begin
          results_due.push_back(make_result('0, ST_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            results_due.push_back(make_result(shadow_ring[(shadow_head + i) % DEPTH],
                                              ST_OK, i == shadow_count - 1));
          end
        end
      end
      default: ;  // unused codes are swallowed
    endcase
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_request(input logic [OP_W-1:0] op,
                             input logic signed [VALUE_W-1:0] v);
    requests_todo.push_back(deq_request_t'{op: op, value: v});
  endtask

  // Request driver: predicts on acceptance, then offers the next request
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        apply_deque_op(s_axis_tuser, s_axis_tdata);
        sent_cnt <= sent_cnt + 1;
      end
      if (requests_todo.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        s_axis_tuser  <= requests_todo[0].op;
        s_axis_tdata  <= requests_todo[0].value;
        s_axis_tvalid <= 1'b1;
        void'(requests_todo.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    deq_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          fail_cnt = fail_cnt + 1;
          $display("%0t: unexpected result value %0d status %0d last %0b", $time,
                   $signed(m_axis_tdata[31:0]), m_axis_tdata[33:32], m_axis_tlast);
        end else begin
          want = results_due.pop_front();
          if (m_axis_tdata[31:0] !== want.value) begin
            fail_cnt = fail_cnt + 1;
            $display("%0t: value expected %0d actual %0d", $time, want.value,
                     $signed(m_axis_tdata[31:0]));
          end
          if (m_axis_tdata[33:32] !== want.status) begin
            fail_cnt = fail_cnt + 1;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_axis_tdata[33:32]);
          end
          if (m_axis_tlast !== want.last) begin
            fail_cnt = fail_cnt + 1;
            $display("%0t: last expected %0b actual %0b", $time, want.last, m_axis_tlast);
          end
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus build, reset and end of run
  initial begin
    int useful;
    int est;
    int mode;
    int r;
    logic front;

    // Directed: empty answers, ignored codes, extremes, refill after emptying
    add_request(OP_POP_FRONT, 32'sd5);
    add_request(OP_POP_BACK, 32'sd9);
    add_request(OP_DUMP, -1);
    add_request(3'd5, 32'sh1234_5678);
    add_request(3'd6, 32'sh7fff_ffff);
    add_request(3'd7, 32'sh8000_0000);
    add_request(OP_PUSH_BACK, 32'sh7fff_ffff);
    add_request(OP_PUSH_FRONT, 32'sh8000_0000);
    add_request(OP_PUSH_BACK, '0);
    add_request(OP_PUSH_FRONT, -1);
    add_request(OP_DUMP, '0);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_POP_BACK, '0);
    add_request(OP_DUMP, '0);
    add_request(OP_PUSH_BACK, 32'shaaaa_aaaa);
    add_request(OP_PUSH_FRONT, 32'sh5555_5555);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_POP_BACK, '0);
    add_request(OP_POP_FRONT, '0);
    add_request(OP_DUMP, '0);
    add_request(OP_PUSH_BACK, 32'sd1);
    add_request(OP_POP_FRONT, '0);

    // Random blocks: fill to full, drain, balanced, mostly-push
    useful = 0;
    est = 0;
    for (int blk = 0; useful < NUM_ITEMS; blk++) begin
      mode = (blk == 0) ? 0 : $urandom_range(3);
      for (int k = 0; k < 40 && useful < NUM_ITEMS; k++) begin
        r = $urandom_range(99);
        front = 1'($urandom_range(1));
        if (r < 3) begin
          add_request(3'd5 + 3'($urandom_range(2)), $urandom);
          continue;
        end
        r = $urandom_range(99);
        case (mode)
          0: begin
            if (est < DEPTH) r = (r < 95) ? 0 : 99;
            else r = (r < 50) ? 0 : (r < 70) ? 99 : 60;
          end
          1: r = (r < 20) ? 0 : (r < 95) ? 60 : 99;
          2: r = (r < 47) ? 0 : (r < 94) ? 60 : 99;
          default: r = (r < 75) ? 0 : (r < 94) ? 60 : 99;
        endcase
        if (r < 50) begin
          add_request(front ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
          if (est < DEPTH) est++;
        end else if (r < 90) begin
          add_request(front ? OP_POP_FRONT : OP_POP_BACK, $urandom);
          if (est > 0) est--;
        end else begin
          add_request(OP_DUMP, $urandom);
        end
        useful++;
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (requests_todo.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_cnt == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/deq_pkg.sv
hw/rtl/deq_front.sv
hw/rtl/deq_cmdq.sv
hw/rtl/deq_back.sv
hw/rtl/double_ended_queue.sv
sim/double_ended_queue_test.sv
